>>> rtl/core/sfd_pkg.sv
package sfd_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int NUM_CHAN    = 10;
  localparam int CHAN_W      = 11;
  localparam int PROD_W      = 22;
  localparam int AGE_W       = 16;
  localparam int DB_W        = 10;

  localparam logic [7:0]        HEADER_BYTE   = 8'h0F;
  localparam logic [7:0]        FOOTER_BYTE   = 8'h00;
  localparam logic [7:0]        LOST_MASK     = 8'h0C;
  localparam logic [CHAN_W-1:0] CHAN_CENTRE   = 11'd1000;
  localparam logic [CHAN_W-1:0] CHAN_OFFSET   = 11'd200;
  localparam logic [CHAN_W-1:0] CHAN_DIVISOR  = 11'd2047;
  localparam logic [AGE_W-1:0]  AGE_MAX       = 16'hFFFF;
  localparam logic [DB_W-1:0]   DEADBAND_RST  = 10'd50;
  localparam logic [AGE_W-1:0]  TIMEOUT_RST   = 16'd100;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_IDLE = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DECODED = 2'd0,
    ST_BAD     = 2'd1,
    ST_LOST    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic {
    REG_DEADBAND = 1'b0,
    REG_TIMEOUT  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } req_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              connected;
    logic [CHAN_W-1:0] chan_1;
    logic [CHAN_W-1:0] chan_2;
    logic [CHAN_W-1:0] chan_3;
    logic [CHAN_W-1:0] chan_4;
    logic [CHAN_W-1:0] chan_5;
    logic [CHAN_W-1:0] chan_6;
    logic [CHAN_W-1:0] chan_7;
    logic [CHAN_W-1:0] chan_8;
    logic [CHAN_W-1:0] chan_9;
    logic [CHAN_W-1:0] chan_10;
  } rsp_item_t;

  typedef struct packed {
    logic    ld_raw;
    logic    ld_prod;
    logic    ld_value;
    status_t status;
  } lane_ctrl_t;

endpackage

>>> rtl/core/sfd_byte_cell.sv
module sfd_byte_cell
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= FOOTER_BYTE;
    end else if (shift) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

>>> rtl/core/sfd_chan_cell.sv
module sfd_chan_cell
  import sfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lane_ctrl_t        ctrl,
  input  logic [DB_W-1:0]   deadband,
  input  logic [CHAN_W-1:0] raw_in,
  output logic [CHAN_W-1:0] value_out
);

  logic [CHAN_W-1:0] raw;
  logic [PROD_W-1:0] prod;
  logic [CHAN_W-1:0] value;
  logic [CHAN_W-1:0] value_next;

  logic [CHAN_W-1:0] quo;
  logic [CHAN_W:0]   rem;
  logic [CHAN_W-1:0] quo_fix;
  logic [CHAN_W-1:0] mapped;
  logic [CHAN_W-1:0] gap;
  logic [CHAN_W-1:0] banded;

  always_ff @(posedge clk) begin
    if (ctrl.ld_raw) begin
      raw <= raw_in;
    end
    if (ctrl.ld_prod) begin
      // x * 1600 as x * (1024 + 512 + 64)
      prod <= {1'b0, raw, 10'd0} + {2'b0, raw, 9'd0} + {5'b0, raw, 6'd0};
    end
  end

  // divide by 2^11 - 1: remainder is low part plus quotient, one correction
  always_comb begin
    quo     = prod[PROD_W-1:CHAN_W];
    rem     = {1'b0, prod[CHAN_W-1:0]} + {1'b0, quo};
    quo_fix = (rem >= {1'b0, CHAN_DIVISOR}) ? quo + 11'd1 : quo;
    // result stays within 200..1800, so no clamp is applied
    mapped  = quo_fix + CHAN_OFFSET;
    gap     = (mapped > CHAN_CENTRE) ? mapped - CHAN_CENTRE : CHAN_CENTRE - mapped;
    banded  = (gap < {1'b0, deadband}) ? CHAN_CENTRE : mapped;
  end

  always_comb begin
    case (ctrl.status)
      ST_DECODED: value_next = banded;
      ST_BAD:     value_next = value;
      default:    value_next = CHAN_CENTRE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= CHAN_CENTRE;
    end else if (ctrl.ld_value) begin
      value <= value_next;
    end
  end

  assign value_out = value;

endmodule

>>> rtl/core/sbus_frame_decoder.sv
// channel | handshake            | payload
// req     | req_valid, req_stall | req_type, rx_byte
// rsp     | rsp_valid, rsp_stall | status, connected, chan_1..chan_10
// cfg     | apb write/read       | deadband (addr 0), timeout_ticks (addr 4)
//
// one item per cycle while req_stall is low; a result passes through s1, s2 and the output register
// the channel lane follows the pipe: raw capture, constant multiply, divide and deadband
// reset clears the byte chain, link state and channel values (all 1000)
// rsp_stall holds the result pipe; req_stall rises only when all three stages are full
module sbus_frame_decoder
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_item_t   req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [DB_W-1:0]  deadband;
  logic [AGE_W-1:0] timeout_ticks;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband      <= DEADBAND_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_DEADBAND) begin
        deadband <= pwdata[DB_W-1:0];
      end else begin
        timeout_ticks <= pwdata[AGE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_DEADBAND) begin
      prdata = {22'd0, deadband};
    end else begin
      prdata = {16'd0, timeout_ticks};
    end
  end

  // result pipe occupancy
  logic    s1_valid, s2_valid;
  status_t s1_status, s2_status, out_status;
  logic    s1_conn, s2_conn, out_conn;
  logic    out_free, s2_free, s1_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign s2_free   = !s2_valid || out_free;
  assign s1_free   = !s1_valid || s2_free;
  assign req_stall = !s1_free;

  logic      accept;
  req_type_t req_kind;
  assign accept   = req_valid && !req_stall;
  assign req_kind = req_type_t'(req.req_type);

  // byte chain: oldest byte at cell 0, newest enters at the far end
  logic [7:0] byte_q [FRAME_BYTES];
  logic       shift_in;
  assign shift_in = accept && (req_kind == REQ_BYTE);

  genvar gi;
  generate
    for (gi = 0; gi < FRAME_BYTES; gi++) begin : g_byte
      logic [7:0] din;
      if (gi == FRAME_BYTES - 1) begin : g_tail
        assign din = req.rx_byte;
      end else begin : g_mid
        assign din = byte_q[gi+1];
      end
      sfd_byte_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift_in),
        .din   (din),
        .dout  (byte_q[gi])
      );
    end
  endgenerate

  // channel bits are packed little-endian from byte 1 onward
  localparam int PAY_BYTES = (NUM_CHAN * CHAN_W + 7) / 8;
  logic [8*PAY_BYTES-1:0] pay_bits;

  generate
    for (gi = 0; gi < PAY_BYTES; gi++) begin : g_pay
      assign pay_bits[8*gi +: 8] = byte_q[gi+1];
    end
  endgenerate

  // frame checks
  logic frame_ok, frame_lost;
  assign frame_ok   = (byte_q[0] == HEADER_BYTE) && (byte_q[FRAME_BYTES-1] == FOOTER_BYTE);
  assign frame_lost = (byte_q[FRAME_BYTES-2] & LOST_MASK) != 8'd0;

  // link watchdog
  logic             link_up, link_up_next;
  logic [AGE_W-1:0] frame_age, frame_age_next, age_inc;
  logic             has_result;
  status_t          new_status;

  assign age_inc = (frame_age == AGE_MAX) ? frame_age : frame_age + 16'd1;

  always_comb begin
    link_up_next   = link_up;
    frame_age_next = frame_age;
    has_result     = 1'b0;
    new_status     = ST_BAD;
    if (accept) begin
      case (req_kind)
        REQ_IDLE: begin
          has_result = 1'b1;
          if (!frame_ok) begin
            new_status = ST_BAD;
          end else if (frame_lost) begin
            new_status   = ST_LOST;
            link_up_next = 1'b0;
          end else begin
            new_status     = ST_DECODED;
            link_up_next   = 1'b1;
            frame_age_next = '0;
          end
        end
        REQ_TICK: begin
          frame_age_next = age_inc;
          if (link_up && (age_inc > timeout_ticks)) begin
            has_result   = 1'b1;
            new_status   = ST_TIMEOUT;
            link_up_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_up   <= 1'b0;
      frame_age <= '0;
    end else begin
      link_up   <= link_up_next;
      frame_age <= frame_age_next;
    end
  end

  // pipe control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= has_result;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        rsp_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (has_result) begin
      s1_status <= new_status;
      s1_conn   <= link_up_next;
    end
    if (s1_valid && s2_free) begin
      s2_status <= s1_status;
      s2_conn   <= s1_conn;
    end
    if (s2_valid && out_free) begin
      out_status <= s2_status;
      out_conn   <= s2_conn;
    end
  end

  // channel lanes: value register at the tail holds channel state
  lane_ctrl_t        lane_ctrl;
  logic [CHAN_W-1:0] chan_val [NUM_CHAN];

  assign lane_ctrl.ld_raw   = has_result && (new_status == ST_DECODED);
  assign lane_ctrl.ld_prod  = s1_valid && s2_free;
  assign lane_ctrl.ld_value = s2_valid && out_free;
  assign lane_ctrl.status   = s2_status;

  generate
    for (gi = 0; gi < NUM_CHAN; gi++) begin : g_chan
      sfd_chan_cell u_lane (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (lane_ctrl),
        .deadband  (deadband),
        .raw_in    (pay_bits[CHAN_W*gi +: CHAN_W]),
        .value_out (chan_val[gi])
      );
    end
  endgenerate

  assign rsp.status    = out_status;
  assign rsp.connected = out_conn;
  assign rsp.chan_1    = chan_val[0];
  assign rsp.chan_2    = chan_val[1];
  assign rsp.chan_3    = chan_val[2];
  assign rsp.chan_4    = chan_val[3];
  assign rsp.chan_5    = chan_val[4];
  assign rsp.chan_6    = chan_val[5];
  assign rsp.chan_7    = chan_val[6];
  assign rsp.chan_8    = chan_val[7];
  assign rsp.chan_9    = chan_val[8];
  assign rsp.chan_10   = chan_val[9];

endmodule
